@@ sv/nts_pkg.sv @@
// Package for the nearest timestamp lookup block.
// Holds the transaction kind codes, the result status codes and the field widths.
// No dependencies.
`timescale 1ns / 1ps

package nts_pkg;

  localparam int unsigned TIME_W        = 32;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_INDEX_W = 10;
  localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TIME_W-1:0]   time_t;

  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_APPEND = 2'd1;
  localparam kind_t KIND_QUERY  = 2'd2;

  localparam status_t ST_EXACT   = 2'd0;
  localparam status_t ST_NEAREST = 2'd1;
  localparam status_t ST_SPAN    = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

endpackage

@@ sv/nearest_timestamp_lookup.sv @@
// Top level of the nearest timestamp lookup block: descending time table and search sequencer.
// Depends on nts_pkg for codes and widths.
//
// Channel   Signals                              Direction  Moves
// input     in_valid, in_ready, kind, time_value  in         one clear, append or query
// output    out_valid, out_ready, status,         out        one result per query
//           entry_index, entry_time
//
// Clear and append transactions complete without leaving the idle state. A query against
// an empty table or outside the stored span goes straight to the response state. Otherwise
// each probe of the single table read port passes a read state and a compare state, first
// for the search and then, when the nearest entry above the searched value must be traced
// to its first copy, for a second search. A synchronous reset empties the table; the table
// contents need no clearing. The input side is held off while a query is in progress and
// while a finished result waits for a free output register.
`timescale 1ns / 1ps

module nearest_timestamp_lookup
  import nts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        kind,
  input  logic [TIME_W-1:0]        time_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [ENTRY_INDEX_W-1:0] entry_index,
  output logic [TIME_W-1:0]        entry_time
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SRCH_RD  = 6'b000010,
    S_SRCH_CMP = 6'b000100,
    S_LB_RD    = 6'b001000,
    S_LB_CMP   = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t state, state_next;

  time_t time_store [TABLE_DEPTH];
  time_t rd_data;
  logic [IW-1:0] mem_addr;

  logic [CW-1:0] entry_count;
  time_t first_time;
  time_t last_time;

  time_t query_time;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi_p1;
  logic [IW-1:0] mid;
  logic [IW-1:0] lb_l;
  logic [IW-1:0] lb_h;
  time_t up_val;
  time_t dn_val;

  status_t res_status;
  logic [IW-1:0] res_index;
  time_t res_time;

  logic accept;
  logic append_ok;
  logic [CW:0] srch_sum;
  logic [IW-1:0] srch_mid;
  logic [IW:0] lb_sum;
  logic [IW-1:0] lb_mid;
  time_t d_up;
  time_t d_dn;
  logic out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign append_ok = (entry_count < CW'(TABLE_DEPTH)) &&
                     ((entry_count == '0) || (time_value <= last_time));
  assign srch_sum  = {1'b0, lo} + {1'b0, hi_p1} - (CW+1)'(1);
  assign srch_mid  = IW'(srch_sum >> 1);
  assign lb_sum    = {1'b0, lb_l} + {1'b0, lb_h};
  assign lb_mid    = IW'(lb_sum >> 1);
  assign d_up      = up_val - query_time;
  assign d_dn      = query_time - dn_val;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    mem_addr   = srch_mid;
    unique case (state)
      S_IDLE: begin
        if (accept && kind == KIND_QUERY) begin
          if (entry_count == '0 || time_value > first_time || time_value < last_time) begin
            state_next = S_RESP;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (lo < hi_p1) begin
          state_next = S_SRCH_CMP;
        end else if (d_dn < d_up) begin
          state_next = S_RESP;
        end else begin
          state_next = S_LB_RD;
        end
      end
      S_SRCH_CMP: begin
        if (rd_data == query_time) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_LB_RD: begin
        mem_addr = lb_mid;
        if (lb_l < lb_h) begin
          state_next = S_LB_CMP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_LB_CMP: begin
        state_next = S_LB_RD;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= time_store[mem_addr];
    if (accept && kind == KIND_APPEND && append_ok) begin
      time_store[IW'(entry_count)] <= time_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (kind)
          KIND_CLEAR: begin
            entry_count <= '0;
          end
          KIND_APPEND: begin
            if (append_ok) begin
              entry_count <= entry_count + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_APPEND && append_ok) begin
      last_time <= time_value;
      if (entry_count == '0) begin
        first_time <= time_value;
      end
    end
    unique case (state)
      S_IDLE: begin
        query_time <= time_value;
        lo         <= '0;
        hi_p1      <= entry_count;
        up_val     <= first_time;
        dn_val     <= last_time;
        res_index  <= '0;
        res_time   <= '0;
        if (entry_count == '0) begin
          res_status <= ST_EMPTY;
        end else begin
          res_status <= ST_SPAN;
        end
      end
      S_SRCH_RD: begin
        mid        <= srch_mid;
        lb_l       <= '0;
        lb_h       <= IW'(lo - CW'(1));
        res_status <= ST_NEAREST;
        res_index  <= IW'(lo);
        res_time   <= dn_val;
      end
      S_SRCH_CMP: begin
        if (rd_data == query_time) begin
          res_status <= ST_EXACT;
          res_index  <= mid;
          res_time   <= rd_data;
        end else if (rd_data > query_time) begin
          lo     <= CW'(mid) + CW'(1);
          up_val <= rd_data;
        end else begin
          hi_p1  <= CW'(mid);
          dn_val <= rd_data;
        end
      end
      S_LB_RD: begin
        mid        <= lb_mid;
        res_status <= ST_NEAREST;
        res_index  <= lb_l;
        res_time   <= up_val;
      end
      S_LB_CMP: begin
        if (rd_data <= up_val) begin
          lb_h <= mid;
        end else begin
          lb_l <= mid + IW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          status      <= res_status;
          entry_index <= ENTRY_INDEX_W'(res_index);
          entry_time  <= res_time;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
